@@ hw/rtl/csm_pkg.sv @@
// shared types, codes and constants of the sparse matrix-vector block
package csm_pkg;

    localparam int VEC_DEPTH_DEF = 1024;
    localparam int FRAC_BITS_DEF = 16;

    localparam int FUNC_W    = 2;
    localparam int IDX_W     = 10;
    localparam int VAL_W     = 32;
    localparam int CNT_W     = 11;
    localparam int ACC_W     = 48;
    localparam int CFG_IDX_W = 2;

    localparam int MUL_A_W = 64;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam logic [FUNC_W-1:0] FUNC_LOAD_X  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_Y  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_NONZERO = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_READ_Y  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_GAIN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSE_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT      = 2'd3;

    localparam logic [VAL_W-1:0] ALPHA_RESET     = 32'd65536;
    localparam logic [CNT_W-1:0] ROW_COUNT_RESET = 11'd1024;
    localparam logic [CNT_W-1:0] COL_COUNT_RESET = 11'd1024;

    // request to the shared multiplier: a (two's complement) times b
    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

endpackage

@@ hw/rtl/csr_sparse_matvec.sv @@
// sparse matrix times vector (y += alpha*A*x or alpha*A^T*x) in q16.16, one word at a time
// a load writes its ram on acceptance; a y read waits in S_READ for a free output slot
// a nonzero runs S_MUL1, S_WAIT1; a row end in range adds S_MUL2, S_WAIT2 (only those
// if its column is out of range); a transposed nonzero runs all four; a no-op stays idle
// reset (synchronous, active low) clears the row accumulator and loads the register defaults
// x and y live in rams that hold garbage until written; there is no clearing pass
module csr_sparse_matvec #(
    parameter int VEC_DEPTH = csm_pkg::VEC_DEPTH_DEF,
    parameter int FRAC_BITS = csm_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // item input channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [csm_pkg::FUNC_W-1:0]         i_func,
    input  logic [csm_pkg::IDX_W-1:0]          i_row_index,
    input  logic [csm_pkg::IDX_W-1:0]          i_col_index,
    input  logic signed [csm_pkg::VAL_W-1:0]   i_value,
    input  logic                               i_row_end,
    // read-back channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [csm_pkg::VAL_W-1:0]   o_read_value,
    output logic [csm_pkg::IDX_W-1:0]          o_read_index,
    // register write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [csm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [csm_pkg::VAL_W-1:0]          i_cfg_data
);

    localparam int AddrW = $clog2(VEC_DEPTH);
    localparam int ValW  = csm_pkg::VAL_W;
    localparam int AccW  = csm_pkg::ACC_W;
    localparam int ProdW = csm_pkg::PROD_W;
    localparam int MulAW = csm_pkg::MUL_A_W;

    // shifted products are clamped to a width where the later saturation still decides alike
    localparam int AccQW = AccW + 2;
    localparam int YQW   = ValW + 3;
    localparam logic signed [ProdW-1:0] AccQMax = (ProdW'(1) <<< (AccQW - 1)) - ProdW'(1);
    localparam logic signed [ProdW-1:0] AccQMin = -(ProdW'(1) <<< (AccQW - 1));
    localparam logic signed [ProdW-1:0] YQMax   = (ProdW'(1) <<< (YQW - 1)) - ProdW'(1);
    localparam logic signed [ProdW-1:0] YQMin   = -(ProdW'(1) <<< (YQW - 1));

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;   // y word on ram output, wait for output slot
    localparam logic [2:0] S_MUL1  = 3'd2;   // x word on ram output, start first product
    localparam logic [2:0] S_WAIT1 = 3'd3;
    localparam logic [2:0] S_MUL2  = 3'd4;   // start product that updates y
    localparam logic [2:0] S_WAIT2 = 3'd5;

    logic [2:0] r_state, n_state;

    // configuration registers
    logic signed [ValW-1:0]          r_alpha;
    logic                            r_transpose;
    logic [csm_pkg::CNT_W-1:0]       r_row_count;
    logic [csm_pkg::CNT_W-1:0]       r_col_count;

    // row accumulator
    logic signed [AccW-1:0]          r_acc, n_acc;

    // latched item
    logic signed [ValW-1:0]          r_value;
    logic                            r_row_end;
    logic                            r_row_ok;
    logic                            r_in_vec;
    logic [csm_pkg::IDX_W-1:0]       r_y_addr;
    logic signed [MulAW-1:0]         r_scaled;

    // output register
    logic                            r_out_valid;
    logic signed [ValW-1:0]          r_read_value;
    logic [csm_pkg::IDX_W-1:0]       r_read_index;

    // item decode
    logic                            in_acc;
    logic                            row_in_vec;
    logic                            row_ok;
    logic                            col_ok;
    logic [csm_pkg::IDX_W-1:0]       y_addr_in;
    logic                            out_free;

    // rams
    logic                            x_we;
    logic [ValW-1:0]                 x_rdata;
    logic                            y_we;
    logic [ValW-1:0]                 y_rdata;
    logic [csm_pkg::IDX_W-1:0]       y_raddr;
    logic [csm_pkg::IDX_W-1:0]       y_waddr;
    logic [ValW-1:0]                 y_wdata;

    // multiplier and arithmetic after it
    csm_pkg::t_mul_req               mul_req;
    logic                            mul_done;
    logic signed [ProdW-1:0]         mul_prod;
    logic signed [ProdW-1:0]         q;
    logic signed [AccQW-1:0]         q_acc;
    logic signed [AccQW:0]           acc_sum;
    logic signed [AccW-1:0]          acc_sat;
    logic signed [YQW-1:0]           q_y;
    logic signed [YQW:0]             y_sum;
    logic signed [ValW-1:0]          y_new;

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free   = !r_out_valid || !i_out_stall;

    // index checks against the store depth and the matrix size in use
    assign row_in_vec = (32'(i_row_index) < 32'(VEC_DEPTH));
    assign row_ok     = row_in_vec && ({1'b0, i_row_index} < r_row_count);
    assign col_ok     = (32'(i_col_index) < 32'(VEC_DEPTH)) && ({1'b0, i_col_index} < r_col_count);

    // transposed nonzeros update y at the column, everything else at the row
    assign y_addr_in = (i_func == csm_pkg::FUNC_NONZERO && r_transpose) ? i_col_index
                                                                        : i_row_index;

    // ram addressing: the y read address is held through an item so its word stays put
    assign y_raddr = (r_state == S_IDLE) ? y_addr_in : r_y_addr;
    assign y_waddr = (r_state == S_IDLE) ? i_row_index : r_y_addr;
    assign y_wdata = (r_state == S_IDLE) ? i_value : y_new;

    csm_ram #(
        .WIDTH (ValW),
        .DEPTH (VEC_DEPTH)
    ) u_x_ram (
        .i_clk   (i_clk),
        .i_we    (x_we),
        .i_waddr (AddrW'(i_row_index)),
        .i_wdata (i_value),
        .i_raddr (AddrW'(r_transpose ? i_row_index : i_col_index)),
        .o_rdata (x_rdata)
    );

    csm_ram #(
        .WIDTH (ValW),
        .DEPTH (VEC_DEPTH)
    ) u_y_ram (
        .i_clk   (i_clk),
        .i_we    (y_we),
        .i_waddr (AddrW'(y_waddr)),
        .i_wdata (y_wdata),
        .i_raddr (AddrW'(y_raddr)),
        .o_rdata (y_rdata)
    );

    // first product: x*coeff (normal) or x*alpha (transposed)
    // second product: acc*alpha (normal row end) or scaled*coeff (transposed)
    always_comb begin
        mul_req.start = (r_state == S_MUL1) || (r_state == S_MUL2);
        if (r_state == S_MUL1) begin
            mul_req.a = {{(MulAW-ValW){x_rdata[ValW-1]}}, x_rdata};
            mul_req.b = r_transpose ? r_alpha : r_value;
        end else if (r_transpose) begin
            mul_req.a = r_scaled;
            mul_req.b = r_value;
        end else begin
            mul_req.a = {{(MulAW-AccW){r_acc[AccW-1]}}, r_acc};
            mul_req.b = r_alpha;
        end
    end

    csm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // drop fraction bits with floor rounding
    assign q = mul_prod >>> FRAC_BITS;

    // accumulator update with 48-bit saturation
    always_comb begin
        if (q > AccQMax) begin
            q_acc = AccQMax[AccQW-1:0];
        end else if (q < AccQMin) begin
            q_acc = AccQMin[AccQW-1:0];
        end else begin
            q_acc = q[AccQW-1:0];
        end
        acc_sum = {{(AccQW-AccW+1){r_acc[AccW-1]}}, r_acc} + {q_acc[AccQW-1], q_acc};
        if ((&acc_sum[AccQW:AccW-1]) || !(|acc_sum[AccQW:AccW-1])) begin
            acc_sat = acc_sum[AccW-1:0];
        end else if (acc_sum[AccQW]) begin
            acc_sat = {1'b1, {(AccW-1){1'b0}}};
        end else begin
            acc_sat = {1'b0, {(AccW-1){1'b1}}};
        end
    end

    // y update with 32-bit saturation
    always_comb begin
        if (q > YQMax) begin
            q_y = YQMax[YQW-1:0];
        end else if (q < YQMin) begin
            q_y = YQMin[YQW-1:0];
        end else begin
            q_y = q[YQW-1:0];
        end
        y_sum = {{(YQW-ValW+1){y_rdata[ValW-1]}}, y_rdata} + {q_y[YQW-1], q_y};
        if ((&y_sum[YQW:ValW-1]) || !(|y_sum[YQW:ValW-1])) begin
            y_new = y_sum[ValW-1:0];
        end else if (y_sum[YQW]) begin
            y_new = {1'b1, {(ValW-1){1'b0}}};
        end else begin
            y_new = {1'b0, {(ValW-1){1'b1}}};
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_acc   = r_acc;
        x_we    = 1'b0;
        y_we    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_func)
                        csm_pkg::FUNC_LOAD_X: x_we = row_in_vec;
                        csm_pkg::FUNC_LOAD_Y: y_we = row_in_vec;
                        csm_pkg::FUNC_READ_Y: n_state = S_READ;
                        csm_pkg::FUNC_NONZERO: begin
                            if (row_ok && col_ok) begin
                                n_state = S_MUL1;
                            end else if (!r_transpose && i_row_end) begin
                                // nothing to add, but the row end still takes effect
                                if (row_ok) begin
                                    n_state = S_MUL2;
                                end else begin
                                    n_acc = '0;
                                end
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_READ: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_MUL1: n_state = S_WAIT1;
            S_WAIT1: begin
                if (mul_done) begin
                    if (r_transpose) begin
                        n_state = S_MUL2;
                    end else begin
                        n_acc = acc_sat;
                        if (!r_row_end) begin
                            n_state = S_IDLE;
                        end else if (r_row_ok) begin
                            n_state = S_MUL2;
                        end else begin
                            n_acc   = '0;
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            S_MUL2: n_state = S_WAIT2;
            S_WAIT2: begin
                if (mul_done) begin
                    y_we = 1'b1;
                    if (!r_transpose) begin
                        n_acc = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
            r_alpha     <= csm_pkg::ALPHA_RESET;
            r_transpose <= 1'b0;
            r_row_count <= csm_pkg::ROW_COUNT_RESET;
            r_col_count <= csm_pkg::COL_COUNT_RESET;
        end else begin
            r_state <= n_state;
            r_acc   <= n_acc;
            if (r_state == S_READ && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    csm_pkg::CFG_ALPHA_GAIN:     r_alpha     <= i_cfg_data;
                    csm_pkg::CFG_TRANSPOSE_MODE: r_transpose <= i_cfg_data[0];
                    csm_pkg::CFG_ROW_COUNT:      r_row_count <= i_cfg_data[csm_pkg::CNT_W-1:0];
                    csm_pkg::CFG_COL_COUNT:      r_col_count <= i_cfg_data[csm_pkg::CNT_W-1:0];
                    default:                     r_transpose <= r_transpose;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_value   <= i_value;
            r_row_end <= i_row_end;
            r_row_ok  <= row_ok;
            r_in_vec  <= row_in_vec;
            r_y_addr  <= y_addr_in;
        end
        if (r_state == S_WAIT1 && mul_done) begin
            r_scaled <= q[MulAW-1:0];
        end
        if (r_state == S_READ && out_free) begin
            r_read_value <= r_in_vec ? y_rdata : '0;
            r_read_index <= r_y_addr;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_read_index = r_read_index;

endmodule

@@ hw/rtl/csm_ram.sv @@
// generic single-write, single-read ram with registered read data
module csm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/csm_mul.sv @@
// multi-cycle signed 64x32 multiplier built on one 33x32 partial product unit
module csm_mul (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  csm_pkg::t_mul_req                i_req,
    output logic                             o_done,
    output logic signed [csm_pkg::PROD_W-1:0] o_prod
);

    localparam int HALF_W = csm_pkg::MUL_A_W / 2;
    localparam int PP_W   = HALF_W + 1 + csm_pkg::MUL_B_W;

    localparam logic [1:0] STEP_LO  = 2'd0;
    localparam logic [1:0] STEP_HI  = 2'd1;
    localparam logic [1:0] STEP_SUM = 2'd2;

    logic [csm_pkg::MUL_A_W-1:0]        r_a;
    logic signed [csm_pkg::MUL_B_W-1:0] r_b;
    logic [1:0]                         r_step;
    logic                               r_busy;
    logic                               r_done;
    logic signed [PP_W-1:0]             r_pp_lo;
    logic signed [PP_W-1:0]             r_pp_hi;
    logic signed [csm_pkg::PROD_W-1:0]  r_prod;

    logic signed [HALF_W:0]             m_a;
    logic signed [PP_W-1:0]             m_prod;
    logic signed [csm_pkg::PROD_W-1:0]  sum;

    // low half is unsigned, high half carries the sign
    assign m_a    = (r_step == STEP_LO) ? $signed({1'b0, r_a[HALF_W-1:0]})
                                        : $signed({r_a[csm_pkg::MUL_A_W-1],
                                                   r_a[csm_pkg::MUL_A_W-1:HALF_W]});
    assign m_prod = m_a * r_b;

    assign sum = $signed({r_pp_hi[PP_W-2:0], {HALF_W{1'b0}}})
               + $signed({{(csm_pkg::PROD_W-PP_W){r_pp_lo[PP_W-1]}}, r_pp_lo});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= STEP_LO;
        end else begin
            r_done <= 1'b0;
            if (!r_busy) begin
                if (i_req.start) begin
                    r_busy <= 1'b1;
                    r_step <= STEP_LO;
                end
            end else begin
                unique case (r_step)
                    STEP_LO:  r_step <= STEP_HI;
                    STEP_HI:  r_step <= STEP_SUM;
                    STEP_SUM: begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                        r_step <= STEP_LO;
                    end
                    default:  r_step <= STEP_LO;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy && i_req.start) begin
            r_a <= i_req.a;
            r_b <= $signed(i_req.b);
        end
        if (r_busy && r_step == STEP_LO) begin
            r_pp_lo <= m_prod;
        end
        if (r_busy && r_step == STEP_HI) begin
            r_pp_hi <= m_prod;
        end
        if (r_busy && r_step == STEP_SUM) begin
            r_prod <= sum;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule
